// ===== hdl/nfrf_pkg.sv =====
// ----------------------------------------------------------------------------
// nfrf_pkg
// Shared types and constants for the 4bpp framebuffer rectangle fill block.
// ----------------------------------------------------------------------------
package nfrf_pkg;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    localparam logic OP_FILL = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [7:0] LO_NIBBLE_MASK = 8'h0F;
    localparam logic [7:0] HI_NIBBLE_MASK = 8'hF0;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_RD    = 6'b000100,
        ST_PRD   = 6'b001000,
        ST_PWR   = 6'b010000,
        ST_FIN   = 6'b100000
    } t_state;

    typedef struct packed {
        logic clr_en;
        logic load;
        logic rd_byte;
        logic pix_rd;
        logic pix_wr;
        logic step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_read;
        logic in_empty;
        logic pix_ok;
        logic last_pix;
    } t_status;

endpackage

// ===== hdl/nfrf_ram.sv =====
// ----------------------------------------------------------------------------
// nfrf_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nfrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/nfrf_ctrl.sv =====
// ----------------------------------------------------------------------------
// nfrf_ctrl
// Controller: clearing pass, item sequencing, nibble read-modify-write steps.
// ----------------------------------------------------------------------------
module nfrf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  nfrf_pkg::t_status i_status,
    output nfrf_pkg::t_cmd    o_cmd
);

    nfrf_pkg::t_state r_state, n_state;
    logic             r_ovalid, n_ovalid;
    nfrf_pkg::t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            nfrf_pkg::ST_CLEAR: begin
                w_cmd.clr_en = 1'b1;
                if (i_status.clr_last) begin
                    n_state = nfrf_pkg::ST_IDLE;
                end
            end
            nfrf_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    w_cmd.load = 1'b1;
                    if (i_status.in_read) begin
                        n_state = nfrf_pkg::ST_RD;
                    end else if (i_status.in_empty) begin
                        n_state = nfrf_pkg::ST_FIN;
                    end else begin
                        n_state = nfrf_pkg::ST_PRD;
                    end
                end
            end
            nfrf_pkg::ST_RD: begin
                w_cmd.rd_byte = 1'b1;
                n_state       = nfrf_pkg::ST_FIN;
            end
            nfrf_pkg::ST_PRD: begin
                if (i_status.pix_ok) begin
                    w_cmd.pix_rd = 1'b1;
                    n_state      = nfrf_pkg::ST_PWR;
                end else if (i_status.last_pix) begin
                    n_state = nfrf_pkg::ST_FIN;
                end else begin
                    w_cmd.step = 1'b1;
                end
            end
            nfrf_pkg::ST_PWR: begin
                w_cmd.pix_wr = 1'b1;
                if (i_status.last_pix) begin
                    n_state = nfrf_pkg::ST_FIN;
                end else begin
                    w_cmd.step = 1'b1;
                    n_state    = nfrf_pkg::ST_PRD;
                end
            end
            nfrf_pkg::ST_FIN: begin
                if (!r_ovalid || m_axis_tready) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = nfrf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nfrf_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.load_out) begin
            n_ovalid = 1'b1;
        end else if (m_axis_tready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= nfrf_pkg::ST_CLEAR;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign s_axis_tready = (r_state == nfrf_pkg::ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign o_cmd         = w_cmd;

endmodule

// ===== hdl/nfrf_dp.sv =====
// ----------------------------------------------------------------------------
// nfrf_dp
// Datapath: item registers, pixel walker, frame store and result register.
// ----------------------------------------------------------------------------
module nfrf_dp #(
    parameter int BYTES_PER_ROW = 128,
    parameter int ROWS          = 64,
    parameter int STORE_BYTES   = 8192,
    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1,
    localparam int WW = $clog2(64 * BYTES_PER_ROW + 128)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [nfrf_pkg::IN_DATA_W-1:0]      i_in_data,
    input  logic                                i_in_op,
    input  nfrf_pkg::t_cmd                      i_cmd,
    output nfrf_pkg::t_status                   o_status,
    output logic [nfrf_pkg::OUT_DATA_W-1:0]     o_out_data
);

    logic [7:0]  w_left, w_right;
    logic [5:0]  w_top, w_bottom;
    logic [3:0]  w_shade;
    logic [12:0] w_addr;

    assign w_left   = i_in_data[7:0];
    assign w_top    = i_in_data[13:8];
    assign w_right  = i_in_data[21:14];
    assign w_bottom = i_in_data[27:22];
    assign w_shade  = i_in_data[31:28];
    assign w_addr   = i_in_data[44:32];

    logic [7:0]    r_left, r_right, r_col;
    logic [5:0]    r_bottom, r_row;
    logic [3:0]    r_shade;
    logic [12:0]   r_addr;
    logic          r_op;
    logic [WW-1:0] r_base;
    logic [14:0]   r_count;
    logic [AW-1:0] r_clr;
    logic [7:0]    r_rd_data;
    logic [14:0]   r_count_out;

    logic [WW-1:0] w_where;
    logic          w_pix_ok, w_last, w_addr_ok;
    logic [7:0]    w_q, w_merged;
    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [7:0]    w_wdata;

    assign w_where   = r_base + WW'(r_col[7:1]);
    assign w_pix_ok  = (32'(r_row) < 32'(ROWS)) && (32'(w_where) < 32'(STORE_BYTES));
    assign w_last    = (r_col == r_right) && (r_row == r_bottom);
    assign w_addr_ok = (32'(r_addr) < 32'(STORE_BYTES));

    assign w_merged = r_col[0] ? ((w_q & nfrf_pkg::LO_NIBBLE_MASK) | {r_shade, 4'h0})
                               : ((w_q & nfrf_pkg::HI_NIBBLE_MASK) | {4'h0, r_shade});

    assign w_we    = i_cmd.clr_en | i_cmd.pix_wr;
    assign w_waddr = i_cmd.clr_en ? r_clr : AW'(w_where);
    assign w_wdata = i_cmd.clr_en ? 8'h00 : w_merged;
    assign w_re    = (i_cmd.rd_byte & w_addr_ok) | i_cmd.pix_rd;
    assign w_raddr = i_cmd.rd_byte ? AW'(r_addr) : AW'(w_where);

    nfrf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_in_op;
            r_left   <= w_left;
            r_right  <= w_right;
            r_bottom <= w_bottom;
            r_shade  <= w_shade;
            r_addr   <= w_addr;
            r_col    <= w_left;
            r_row    <= w_top;
            r_base   <= WW'(w_top) * WW'(BYTES_PER_ROW);
            r_count  <= '0;
        end else begin
            if (i_cmd.pix_wr) begin
                r_count <= r_count + 15'd1;
            end
            if (i_cmd.step) begin
                if (r_col == r_right) begin
                    r_col  <= r_left;
                    r_row  <= r_row + 6'd1;
                    r_base <= r_base + WW'(BYTES_PER_ROW);
                end else begin
                    r_col <= r_col + 8'd1;
                end
            end
        end
        if (i_cmd.load_out) begin
            r_rd_data   <= (r_op == nfrf_pkg::OP_READ && w_addr_ok) ? w_q : 8'h00;
            r_count_out <= (r_op == nfrf_pkg::OP_READ) ? 15'd0 : r_count;
        end
    end

    assign o_status.clr_last = (r_clr == AW'(STORE_BYTES - 1));
    assign o_status.in_read  = (i_in_op == nfrf_pkg::OP_READ);
    assign o_status.in_empty = (w_right < w_left) || (w_bottom < w_top);
    assign o_status.pix_ok   = w_pix_ok;
    assign o_status.last_pix = w_last;

    assign o_out_data = {1'b1, r_count_out, r_rd_data};

endmodule

// ===== hdl/nibble_framebuffer_rect_fill.sv =====
// ----------------------------------------------------------------------------
// nibble_framebuffer_rect_fill
// 4bpp framebuffer with rectangle fill and byte read-back.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that zeroes all STORE_BYTES bytes
// of the frame store (8192 by default); s_axis_tready stays low until it ends.
// One item is worked at a time. A read passes through ST_RD, where the frame
// store byte is read, and ST_FIN, where its result is loaded into the output
// register. A fill paints each pixel by a read then a write of its byte (ST_PRD
// then ST_PWR) through the single-read, single-write frame store; a pixel that
// falls outside the store is skipped in ST_PRD. An empty rectangle goes straight
// to ST_FIN. The next item is taken while the previous result waits in the
// output register.
module nibble_framebuffer_rect_fill #(
    parameter int BYTES_PER_ROW = 128,
    parameter int ROWS          = 64,
    parameter int STORE_BYTES   = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // left[7:0], top[13:8], right[21:14], bottom[27:22], shade[31:28],
    // address[44:32], zero pad[47:45]
    input  logic [47:0] s_axis_tdata,
    // op[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], pixels_written[22:8], done_res[23]
    output logic [23:0] m_axis_tdata
);

    nfrf_pkg::t_cmd    w_cmd;
    nfrf_pkg::t_status w_status;

    nfrf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_status      (w_status),
        .o_cmd         (w_cmd)
    );

    nfrf_dp #(
        .BYTES_PER_ROW (BYTES_PER_ROW),
        .ROWS          (ROWS),
        .STORE_BYTES   (STORE_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (s_axis_tdata),
        .i_in_op    (s_axis_tuser),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_data (m_axis_tdata)
    );

    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_cmd.pix_wr && !w_cmd.clr_en)
        else $error("frame store written while idle");

    a_one_mem_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.clr_en, w_cmd.rd_byte, w_cmd.pix_rd, w_cmd.pix_wr}))
        else $error("conflicting frame store commands");

    a_write_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pix_wr |-> $past(w_cmd.pix_rd))
        else $error("nibble write without preceding read");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[22:8] <= 15'd16384)
        else $error("pixel count out of range");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the 4bpp framebuffer rectangle fill block against a nibble-accurate
// shadow of the frame store. Each accepted fill paints the shadow and each
// accepted read looks it up; every result item is compared field by field.
// Directed corner items come first, then random fills with read-back of the
// painted area, under bursty input and a stalling output.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTES_PER_ROW = 128;
    localparam int ROWS          = 64;
    localparam int STORE_BYTES   = 8192;
    localparam int unsigned CYCLE_LIMIT = 5_000_000;

    typedef struct packed {
        logic        done_res;
        logic [14:0] pixels_written;
        logic [7:0]  read_data;
    } t_frame_result;

    class frame_scoreboard;
        logic [7:0]    frame_bytes [STORE_BYTES];
        t_frame_result fill_read_results [$];
        int unsigned   error_count;

        function new();
            foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
            error_count = 0;
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            $display("mismatch %s: got %0d, want %0d", what, got, want);
            error_count++;
        endtask

        // paints or reads the shadow store and queues the result it implies
        function void note_item(logic op, logic [nfrf_pkg::IN_DATA_W-1:0] data);
            logic [7:0]    left_col, right_col;
            logic [5:0]    top_row, bottom_row;
            logic [3:0]    level;
            logic [12:0]   addr;
            int unsigned   where;
            t_frame_result res;
            left_col   = data[7:0];
            top_row    = data[13:8];
            right_col  = data[21:14];
            bottom_row = data[27:22];
            level      = data[31:28];
            addr       = data[44:32];
            res = '0;
            res.done_res = 1'b1;
            if (op == nfrf_pkg::OP_READ) begin
                if (addr < STORE_BYTES) res.read_data = frame_bytes[addr];
            end else if (right_col >= left_col && bottom_row >= top_row) begin
                for (int row = top_row; row <= bottom_row; row++) begin
                    for (int col = left_col; col <= right_col; col++) begin
                        where = col / 2 + row * BYTES_PER_ROW;
                        if (row < ROWS && where < STORE_BYTES) begin
                            if (col % 2 == 1) frame_bytes[where][7:4] = level;
                            else frame_bytes[where][3:0] = level;
                            res.pixels_written = res.pixels_written + 15'd1;
                        end
                    end
                end
            end
            fill_read_results.push_back(res);
        endfunction

        task check_result(logic [nfrf_pkg::OUT_DATA_W-1:0] data);
            t_frame_result got, want;
            got = data;
            if (fill_read_results.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(got), 0);
                return;
            end
            want = fill_read_results.pop_front();
            if (got.read_data !== want.read_data)
                report_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
            if (got.pixels_written !== want.pixels_written)
                report_mismatch("pixels_written", 32'(got.pixels_written),
                                32'(want.pixels_written));
            if (got.done_res !== want.done_res)
                report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
        endtask
    endclass

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 s_axis_tvalid;
    logic                                 s_axis_tready;
    logic [nfrf_pkg::IN_DATA_W-1:0]       s_axis_tdata;
    logic                                 s_axis_tuser;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [nfrf_pkg::OUT_DATA_W-1:0]      m_axis_tdata;

    frame_scoreboard board = new();

    int unsigned cycle_count = 0;
    int unsigned rx_cycle = 0;
    logic        rx_ready;
    logic        hold_off = 1'b0;
    logic        pressure_on = 1'b0;
    int unsigned burst_left = 0;
    int unsigned last_left = 0, last_right = 255, last_top = 0, last_bottom = 63;

    nibble_framebuffer_rect_fill #(
        .BYTES_PER_ROW (BYTES_PER_ROW),
        .ROWS          (ROWS),
        .STORE_BYTES   (STORE_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
        rx_cycle++;
        case ((rx_cycle >> 7) % 3)
            0: begin
                rx_ready = 1'b1;
            end
            1: begin
                rx_ready = 1'($urandom_range(0, 1));
            end
            default: begin
                rx_ready = (rx_cycle % 8) == 0;
            end
        endcase
        m_axis_tready <= i_rst_n && !hold_off && rx_ready;
    end

    // long output stall while the sender keeps offering items
    initial begin
        wait (pressure_on);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    function automatic logic [nfrf_pkg::IN_DATA_W-1:0] pack_item(logic [7:0] l,
                                                                 logic [5:0] t,
                                                                 logic [7:0] r,
                                                                 logic [5:0] b,
                                                                 logic [3:0] shade,
                                                                 logic [12:0] addr);
        return {3'b000, addr, shade, b, r, t, l};
    endfunction

    task automatic offer_item(logic op, logic [nfrf_pkg::IN_DATA_W-1:0] data);
        int unsigned gap;
        if (burst_left == 0 && !pressure_on) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left != 0) burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_item(op, data);
    endtask

    task automatic send_fill(logic [7:0] l, logic [5:0] t, logic [7:0] r, logic [5:0] b,
                             logic [3:0] shade, logic [12:0] addr);
        offer_item(nfrf_pkg::OP_FILL, pack_item(l, t, r, b, shade, addr));
        if (r >= l && b >= t) begin
            last_left = l;
            last_right = r;
            last_top = t;
            last_bottom = b;
        end
    endtask

    task automatic send_read(logic [12:0] addr);
        logic [31:0] noise;
        noise = $urandom();
        offer_item(nfrf_pkg::OP_READ, {3'b000, addr, noise});
    endtask

    // reads mostly land inside the last painted rectangle
    task automatic random_item(bit small_only);
        int unsigned pick, w, h;
        int unsigned l, t, r, b;
        logic [7:0]  x;
        logic [5:0]  y;
        pick = $urandom_range(0, 99);
        if (pick < 32) begin
            x = 8'($urandom_range(last_left, last_right));
            y = 6'($urandom_range(last_top, last_bottom));
            send_read({y, x[7:1]});
        end else if (pick < 45) begin
            send_read(13'($urandom_range(0, STORE_BYTES - 1)));
        end else if (pick < 52) begin
            if ($urandom_range(0, 1) == 0) begin
                l = $urandom_range(1, 255);
                r = $urandom_range(0, l - 1);
                t = $urandom_range(0, 63);
                b = $urandom_range(0, 63);
            end else begin
                t = $urandom_range(1, 63);
                b = $urandom_range(0, t - 1);
                l = $urandom_range(0, 255);
                r = $urandom_range(0, 255);
            end
            send_fill(8'(l), 6'(t), 8'(r), 6'(b), 4'($urandom_range(0, 15)),
                      13'($urandom_range(0, 8191)));
        end else begin
            if (pick < 57 && !small_only) begin
                w = $urandom_range(1, 256);
                h = $urandom_range(1, 16);
            end else begin
                w = $urandom_range(1, 24);
                h = $urandom_range(1, 8);
            end
            l = $urandom_range(0, 255);
            t = $urandom_range(0, 63);
            r = (l + w - 1 > 255) ? 255 : l + w - 1;
            b = (t + h - 1 > 63) ? 63 : t + h - 1;
            send_fill(8'(l), 6'(t), 8'(r), 6'(b), 4'($urandom_range(0, 15)),
                      13'($urandom_range(0, 8191)));
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= nfrf_pkg::OP_FILL;
        s_axis_tdata  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_read(13'd0);
        send_read(13'h1FFF);
        send_fill(8'd0, 6'd0, 8'd255, 6'd63, 4'hF, 13'h0000);
        send_read(13'h1FFF);
        send_read(13'd0);
        send_fill(8'd0, 6'd0, 8'd0, 6'd0, 4'h0, 13'h1FFF);
        send_fill(8'd255, 6'd63, 8'd255, 6'd63, 4'h5, 13'h0AAA);
        send_read(13'd0);
        send_read(13'h1FFF);
        send_fill(8'd10, 6'd0, 8'd9, 6'd0, 4'h3, 13'h1555);
        send_fill(8'd0, 6'd40, 8'd255, 6'd39, 4'h3, 13'h0000);
        send_read(13'd5);
        send_read(13'(5 + 39 * BYTES_PER_ROW));
        send_fill(8'd1, 6'd1, 8'd2, 6'd1, 4'hA, 13'h1FFF);
        send_read(13'd129);
        send_read(13'd130);
        send_fill(8'd254, 6'd0, 8'd255, 6'd63, 4'h6, 13'h0001);
        send_read(13'd127);
        send_read(13'(127 + 32 * BYTES_PER_ROW));
        send_fill(8'd0, 6'd0, 8'd255, 6'd63, 4'h0, 13'h0000);
        send_read(13'd129);

        repeat (40) random_item(1'b0);
        pressure_on = 1'b1;
        repeat (20) random_item(1'b1);
        pressure_on = 1'b0;
        repeat (40) random_item(1'b0);

        s_axis_tvalid <= 1'b0;
        while (board.fill_read_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (board.error_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
